// ===== rtl/gsfl_pkg.sv =====
// Shared constants and types for the gas sensor frame link.
`timescale 1ns / 1ps
package gsfl_pkg;

   // Input word kinds
   localparam logic [1:0] KIND_SEND = 2'd0;
   localparam logic [1:0] KIND_RX   = 2'd1;
   localparam logic [1:0] KIND_IDLE = 2'd2;

   // Output word kinds
   localparam logic OUT_TX      = 1'b0;
   localparam logic OUT_VERDICT = 1'b1;

   localparam int unsigned FRAME_LEN = 9;
   localparam logic [3:0] LAST_BEAT = 4'(FRAME_LEN - 1);

   // Frame constants
   localparam logic [7:0] HDR_START  = 8'hFF;
   localparam logic [7:0] HDR_ADDR   = 8'h01;
   localparam logic [7:0] CMD_READ   = 8'h86;
   localparam logic [7:0] CMD_MODE_A = 8'h78;
   localparam logic [7:0] CMD_MODE_B = 8'hA7;
   localparam logic [7:0] CMD_SPAN   = 8'h88;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);

   // One queued job. For a send: cmd_byte is the command, data[47:40] and
   // data[39:32] the two argument bytes, data[7:0] the checksum.
   // For a verdict: cmd_byte is reply byte 1, data is reply bytes 2..7.
   typedef struct packed {
      logic        is_verdict;
      logic        ok;
      logic [7:0]  cmd_byte;
      logic [47:0] data;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ===== rtl/gas_sensor_frame_link_unit.sv =====
// A job is written into the queue, then loaded into the output register when that is free.
// Received-byte words are taken one per cycle and never stall; a send gives one output
// word per frame byte (nine), a verdict one word; rsp_stall holds them. Four jobs may queue.
// Reset (synchronous, active high) clears receive count and sum, queue, frame beat and
// output valid; the receive store contents stay undefined and are masked by the count.
`timescale 1ns / 1ps
module gas_sensor_frame_link_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_command,
   input  logic [15:0] req_arg_value,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_reply_ok,
   output logic [7:0]  rsp_reply_command,
   output logic [47:0] rsp_reply_data
);

   gsfl_pkg::push_type  push;
   gsfl_pkg::entry_type head;
   logic                q_full, q_empty, pop;

   gsfl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_command   (req_command),
      .req_arg_value (req_arg_value),
      .req_rx_byte   (req_rx_byte),
      .q_full        (q_full),
      .push          (push)
   );

   gsfl_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (head)
   );

   gsfl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .rsp_reply_ok      (rsp_reply_ok),
      .rsp_reply_command (rsp_reply_command),
      .rsp_reply_data    (rsp_reply_data)
   );

endmodule

// ===== rtl/gsfl_front.sv =====
// Front part: accepts input words, keeps the receive store, builds jobs.
`timescale 1ns / 1ps
module gsfl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_command,
   input  logic [15:0]       req_arg_value,
   input  logic [7:0]        req_rx_byte,
   input  logic              q_full,
   output gsfl_pkg::push_type push
);

   logic [7:0] store_ff [gsfl_pkg::FRAME_LEN];
   logic [3:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] slot [gsfl_pkg::FRAME_LEN];
   logic       accept;
   logic [7:0] arg_a, arg_b, tx_chk;
   logic       ok;

   // received bytes never need the queue, so only send and idle stall
   assign req_stall = q_full &&
                      (req_kind == gsfl_pkg::KIND_SEND || req_kind == gsfl_pkg::KIND_IDLE);
   assign accept = req_valid && !req_stall;

   always_comb begin
      for (int k = 0; k < gsfl_pkg::FRAME_LEN; k++) begin
         slot[k] = (4'(k) < count_ff) ? store_ff[k] : 8'h00;
      end
   end

   always_comb begin
      arg_a = 8'h00;
      arg_b = 8'h00;
      if (req_command == gsfl_pkg::CMD_SPAN) begin
         arg_a = req_arg_value[15:8];
         arg_b = req_arg_value[7:0];
      end else if (req_command == gsfl_pkg::CMD_MODE_A ||
                   req_command == gsfl_pkg::CMD_MODE_B) begin
         arg_a = req_arg_value[7:0];
      end
      tx_chk = 8'h00 - (gsfl_pkg::HDR_ADDR + req_command + arg_a + arg_b);
   end

   // running sum of bytes 1..7 is kept as they arrive
   assign ok = (count_ff == 4'(gsfl_pkg::FRAME_LEN)) &&
               (store_ff[0] == gsfl_pkg::HDR_START) &&
               (store_ff[1] == gsfl_pkg::CMD_READ ||
                store_ff[1] == gsfl_pkg::CMD_MODE_A ||
                store_ff[1] == gsfl_pkg::CMD_MODE_B) &&
               (store_ff[8] == 8'(8'h00 - sum_ff));

   always_comb begin
      push.valid = 1'b0;
      push.entry = '0;
      if (accept && req_kind == gsfl_pkg::KIND_SEND) begin
         push.valid            = 1'b1;
         push.entry.is_verdict = 1'b0;
         push.entry.cmd_byte   = req_command;
         push.entry.data       = {arg_a, arg_b, 24'h000000, tx_chk};
      end else if (accept && req_kind == gsfl_pkg::KIND_IDLE && count_ff != 4'd0) begin
         push.valid            = 1'b1;
         push.entry.is_verdict = 1'b1;
         push.entry.ok         = ok;
         push.entry.cmd_byte   = slot[1];
         push.entry.data       = {slot[2], slot[3], slot[4], slot[5], slot[6], slot[7]};
      end
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         unique case (req_kind)
            gsfl_pkg::KIND_SEND, gsfl_pkg::KIND_IDLE: begin
               count_in = 4'd0;
               sum_in   = 8'h00;
            end
            gsfl_pkg::KIND_RX: begin
               if (count_ff < 4'(gsfl_pkg::FRAME_LEN)) begin
                  count_in = count_ff + 4'd1;
                  if (count_ff >= 4'd1 && count_ff <= 4'd7) begin
                     sum_in = sum_ff + req_rx_byte;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         sum_ff   <= 8'h00;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_kind == gsfl_pkg::KIND_RX &&
          count_ff < 4'(gsfl_pkg::FRAME_LEN)) begin
         store_ff[count_ff] <= req_rx_byte;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(gsfl_pkg::FRAME_LEN))
      else $error("receive count beyond frame length");

   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == gsfl_pkg::KIND_IDLE |=> count_ff == 4'd0)
      else $error("idle word did not clear receive store");

endmodule

// ===== rtl/gsfl_queue.sv =====
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
module gsfl_queue (
   input  logic                clock,
   input  logic                reset,
   input  gsfl_pkg::push_type  push,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output gsfl_pkg::entry_type head
);

   gsfl_pkg::entry_type mem_ff [gsfl_pkg::QDEPTH];
   logic [gsfl_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [gsfl_pkg::QPTR_W:0]   fill_ff;

   assign full  = fill_ff == (gsfl_pkg::QPTR_W + 1)'(gsfl_pkg::QDEPTH);
   assign empty = fill_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push.valid, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ===== rtl/gsfl_back.sv =====
// Back part: expands queued jobs into frame bytes and verdict words.
`timescale 1ns / 1ps
module gsfl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  gsfl_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_out_kind,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_last,
   output logic                rsp_reply_ok,
   output logic [7:0]          rsp_reply_command,
   output logic [47:0]         rsp_reply_data
);

   logic [3:0]  beat_ff, beat_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, last_ff, ok_ff;
   logic [7:0]  tx_ff, rcmd_ff;
   logic [47:0] rdata_ff;
   logic        load;
   logic [7:0]  frame_byte;

   assign load = !q_empty && (!valid_ff || !rsp_stall);
   assign pop  = load && (head.is_verdict || beat_ff == gsfl_pkg::LAST_BEAT);

   always_comb begin
      unique case (beat_ff)
         4'd0:    frame_byte = gsfl_pkg::HDR_START;
         4'd1:    frame_byte = gsfl_pkg::HDR_ADDR;
         4'd2:    frame_byte = head.cmd_byte;
         4'd3:    frame_byte = head.data[47:40];
         4'd4:    frame_byte = head.data[39:32];
         4'd8:    frame_byte = head.data[7:0];
         default: frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         if (head.is_verdict || beat_ff == gsfl_pkg::LAST_BEAT) begin
            beat_in = 4'd0;
         end else begin
            beat_in = beat_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (head.is_verdict) begin
            kind_ff  <= gsfl_pkg::OUT_VERDICT;
            tx_ff    <= 8'h00;
            last_ff  <= 1'b1;
            ok_ff    <= head.ok;
            rcmd_ff  <= head.cmd_byte;
            rdata_ff <= head.data;
         end else begin
            kind_ff  <= gsfl_pkg::OUT_TX;
            tx_ff    <= frame_byte;
            last_ff  <= beat_ff == gsfl_pkg::LAST_BEAT;
            ok_ff    <= 1'b0;
            rcmd_ff  <= 8'h00;
            rdata_ff <= '0;
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_kind      = kind_ff;
   assign rsp_tx_byte       = tx_ff;
   assign rsp_last          = last_ff;
   assign rsp_reply_ok      = ok_ff;
   assign rsp_reply_command = rcmd_ff;
   assign rsp_reply_data    = rdata_ff;

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      beat_ff <= gsfl_pkg::LAST_BEAT)
      else $error("frame beat out of range");

   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      beat_ff != 4'd0 |-> !q_empty && !head.is_verdict)
      else $error("frame in progress without a send job at head");

endmodule

// ===== test/gas_sensor_frame_link_check.sv =====
// Frame link monitor: predicts the rsp words from accepted req words and compares them.
`timescale 1ns / 1ps
module gas_sensor_frame_link_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_command,
   input  logic [15:0] req_arg_value,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_out_kind,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_last,
   input  logic        rsp_reply_ok,
   input  logic [7:0]  rsp_reply_command,
   input  logic [47:0] rsp_reply_data,
   output int          mismatch_count,
   output int          words_pending
);

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic        reply_ok;
      logic [7:0]  reply_command;
      logic [47:0] reply_data;
   } link_word_type;

   link_word_type                       expected_words[$];
   logic [gsfl_pkg::FRAME_LEN-1:0][7:0] rx_frame;
   int unsigned                         rx_len;

   function automatic logic [7:0] frame_checksum(
      input logic [gsfl_pkg::FRAME_LEN-1:0][7:0] f);
      logic [7:0] sum;
      int         k;
      sum = 8'd0;
      for (k = 1; k < 8; k++)
         sum += f[k];
      return 8'd0 - sum;
   endfunction

   task automatic check_field(input string name, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic predict_link_words(input logic [1:0] kind, input logic [7:0] cmd,
                                     input logic [15:0] arg, input logic [7:0] rxb);
      logic [gsfl_pkg::FRAME_LEN-1:0][7:0] f;
      link_word_type                       w;
      int                                  k;
      f = '0;
      case (kind)
         gsfl_pkg::KIND_SEND: begin
            f[0] = gsfl_pkg::HDR_START;
            f[1] = gsfl_pkg::HDR_ADDR;
            f[2] = cmd;
            if (cmd == gsfl_pkg::CMD_SPAN) begin
               f[3] = arg[15:8];
               f[4] = arg[7:0];
            end else if (cmd == gsfl_pkg::CMD_MODE_A || cmd == gsfl_pkg::CMD_MODE_B) begin
               f[3] = arg[7:0];
            end
            f[8] = frame_checksum(f);
            for (k = 0; k < gsfl_pkg::FRAME_LEN; k++) begin
               w = '0;
               w.out_kind = gsfl_pkg::OUT_TX;
               w.tx_byte = f[k];
               w.last = (k == gsfl_pkg::FRAME_LEN - 1);
               expected_words.push_back(w);
            end
            rx_len = 0;
         end
         gsfl_pkg::KIND_RX: begin
            // bytes past the ninth are dropped
            if (rx_len < gsfl_pkg::FRAME_LEN) begin
               rx_frame[rx_len] = rxb;
               rx_len++;
            end
         end
         gsfl_pkg::KIND_IDLE: begin
            if (rx_len != 0) begin
               for (k = 0; k < gsfl_pkg::FRAME_LEN; k++)
                  f[k] = (k < rx_len) ? rx_frame[k] : 8'd0;
               w = '0;
               w.out_kind = gsfl_pkg::OUT_VERDICT;
               w.last = 1'b1;
               w.reply_ok = (rx_len == gsfl_pkg::FRAME_LEN) &&
                            (f[0] == gsfl_pkg::HDR_START) &&
                            (f[1] == gsfl_pkg::CMD_READ || f[1] == gsfl_pkg::CMD_MODE_A ||
                             f[1] == gsfl_pkg::CMD_MODE_B) && (frame_checksum(f) == f[8]);
               w.reply_command = f[1];
               w.reply_data = {f[2], f[3], f[4], f[5], f[6], f[7]};
               expected_words.push_back(w);
            end
            rx_len = 0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      link_word_type want;
      if (reset) begin
         expected_words.delete();
         rx_frame = '0;
         rx_len = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected rsp word: out_kind %0d tx_byte %h", rsp_out_kind,
                      rsp_tx_byte);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("out_kind", 48'(want.out_kind), 48'(rsp_out_kind));
               check_field("tx_byte", 48'(want.tx_byte), 48'(rsp_tx_byte));
               check_field("last", 48'(want.last), 48'(rsp_last));
               check_field("reply_ok", 48'(want.reply_ok), 48'(rsp_reply_ok));
               check_field("reply_command", 48'(want.reply_command),
                           48'(rsp_reply_command));
               check_field("reply_data", want.reply_data, rsp_reply_data);
            end
         end
         if (req_valid && !req_stall)
            predict_link_words(req_kind, req_command, req_arg_value, req_rx_byte);
      end
      words_pending = expected_words.size();
   end

endmodule

// ===== test/gas_sensor_frame_link_unit_tb.sv =====
// Testbench top for the gas sensor frame link: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module gas_sensor_frame_link_unit_tb;

   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 320;
   localparam int         HOLD_AT      = 150;
   localparam int         HOLD_LEN     = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = gsfl_pkg::KIND_IDLE;
   logic [7:0]  req_command = 8'd0;
   logic [15:0] req_arg_value = 16'd0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_out_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        rsp_reply_ok;
   logic [7:0]  rsp_reply_command;
   logic [47:0] rsp_reply_data;

   int mismatch_count;
   int words_pending;
   int burst_left = 0;
   int items_offered = 0;

   gas_sensor_frame_link_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_command       (req_command),
      .req_arg_value     (req_arg_value),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .rsp_reply_ok      (rsp_reply_ok),
      .rsp_reply_command (rsp_reply_command),
      .rsp_reply_data    (rsp_reply_data)
   );

   gas_sensor_frame_link_check i_frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_command       (req_command),
      .req_arg_value     (req_arg_value),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .rsp_reply_ok      (rsp_reply_ok),
      .rsp_reply_command (rsp_reply_command),
      .rsp_reply_data    (rsp_reply_data),
      .mismatch_count    (mismatch_count),
      .words_pending     (words_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #800000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [7:0] frame_checksum(input logic [8:0][7:0] f);
      logic [7:0] sum;
      int         k;
      sum = 8'd0;
      for (k = 1; k < 8; k++)
         sum += f[k];
      return 8'd0 - sum;
   endfunction

   // Sender side: random bursts separated by random gaps; payload held while stalled.
   task automatic offer_word(input logic [1:0] kind, input logic [7:0] cmd,
                             input logic [15:0] arg, input logic [7:0] rxb);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_command   <= cmd;
      req_arg_value <= arg;
      req_rx_byte   <= rxb;
      if (kind != KIND_UNUSED)
         items_offered++;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic send_command(input logic [7:0] cmd, input logic [15:0] arg);
      offer_word(gsfl_pkg::KIND_SEND, cmd, arg, 8'($urandom));
   endtask

   task automatic receive_byte(input logic [7:0] b);
      offer_word(gsfl_pkg::KIND_RX, 8'($urandom), 16'($urandom), b);
   endtask

   task automatic line_idle();
      offer_word(gsfl_pkg::KIND_IDLE, 8'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // Reply frame of n_bytes (extra bytes past nine are random), then line idle.
   task automatic receive_reply(input logic [7:0] hdr, input logic [7:0] cmd,
                                input logic [47:0] data, input int n_bytes,
                                input bit bad_sum);
      logic [8:0][7:0] f;
      int              k;
      f = '0;
      f[0] = hdr;
      f[1] = cmd;
      {f[2], f[3], f[4], f[5], f[6], f[7]} = data;
      f[8] = frame_checksum(f) + (bad_sum ? 8'($urandom_range(1, 255)) : 8'd0);
      for (k = 0; k < n_bytes; k++)
         receive_byte((k < 9) ? f[k] : 8'($urandom));
      line_idle();
   endtask

   // Receiver side: stall pattern in phases, plus one long hold-off to fill the block.
   initial begin
      int cyc;
      int mode;
      int span;
      bit held;
      cyc = 0;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 60);
         repeat (span) begin
            @(posedge clock);
            cyc++;
            if (!held && cyc >= HOLD_AT) begin
               held = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_LEN) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 7) == 0);
                  default: rsp_stall <= (cyc % 3 == 0);
               endcase
            end
         end
      end
   end

   initial begin
      int          r;
      int          k;
      int          n;
      logic [7:0]  reply_cmd;
      logic [7:0]  send_cmd;
      logic [15:0] arg;
      logic [47:0] data;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_command(gsfl_pkg::CMD_SPAN, 16'hFFFF);
      send_command(gsfl_pkg::CMD_SPAN, 16'h12FE);
      send_command(gsfl_pkg::CMD_MODE_A, 16'hAB55);
      send_command(gsfl_pkg::CMD_MODE_B, 16'hFFFF);
      send_command(8'h00, 16'hFFFF);
      send_command(8'hFF, 16'h8001);
      // nothing received yet: no verdict
      line_idle();
      offer_word(KIND_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
      receive_reply(gsfl_pkg::HDR_START, gsfl_pkg::CMD_READ, 48'hFFFF_FFFF_FFFF, 9, 1'b0);
      // short reply: missing slots read as zero
      receive_reply(gsfl_pkg::HDR_START, gsfl_pkg::CMD_MODE_A, 48'h0, 2, 1'b0);

      items_offered = 0;
      while (items_offered < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: reply_cmd = gsfl_pkg::CMD_READ;
            1: reply_cmd = gsfl_pkg::CMD_MODE_A;
            2: reply_cmd = gsfl_pkg::CMD_MODE_B;
            default: reply_cmd = 8'($urandom);
         endcase
         case ($urandom_range(0, 4))
            0: send_cmd = gsfl_pkg::CMD_SPAN;
            1: send_cmd = gsfl_pkg::CMD_MODE_A;
            2: send_cmd = gsfl_pkg::CMD_MODE_B;
            3: send_cmd = gsfl_pkg::CMD_READ;
            default: send_cmd = 8'($urandom);
         endcase
         arg = ($urandom_range(0, 7) == 0) ? {16{1'($urandom_range(0, 1))}}
                                            : 16'($urandom);
         data = ($urandom_range(0, 7) == 0) ? {48{1'($urandom_range(0, 1))}}
                                             : {16'($urandom), 32'($urandom)};
         r = $urandom_range(0, 99);
         if (r < 40) begin
            receive_reply(gsfl_pkg::HDR_START, reply_cmd, data, 9, 1'b0);
         end else if (r < 55) begin
            case ($urandom_range(0, 4))
               0: receive_reply(8'($urandom_range(0, 254)), reply_cmd, data, 9, 1'b0);
               1: receive_reply(gsfl_pkg::HDR_START, 8'($urandom), data, 9, 1'b0);
               2: receive_reply(gsfl_pkg::HDR_START, reply_cmd, data, 9, 1'b1);
               3: receive_reply(gsfl_pkg::HDR_START, reply_cmd, data,
                                $urandom_range(1, 8), 1'b0);
               default: receive_reply(gsfl_pkg::HDR_START, reply_cmd, data,
                                      $urandom_range(10, 13), 1'b0);
            endcase
         end else if (r < 80) begin
            send_command(send_cmd, arg);
         end else if (r < 90) begin
            if ($urandom_range(0, 1))
               receive_byte(8'($urandom));
            else
               line_idle();
         end else if (r < 95) begin
            offer_word(KIND_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            // send in the middle of a reply clears the partial frame
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
               receive_byte(8'($urandom));
            send_command(send_cmd, arg);
            if ($urandom_range(0, 1))
               line_idle();
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
